// File: hw/rtl/vdu_pkg.sv
`default_nettype none
package vdu_pkg;

    // Element and accumulator formats
    localparam int ELEMENT_BITS  = 16;
    localparam int FRACTION_BITS = 12;
    localparam int ACC_W         = 40;
    localparam int OUT_W         = 41;
    localparam int PROD_W        = 2 * (ELEMENT_BITS + 1);
    localparam int RAD_W         = 2 * ACC_W;
    localparam int ROOT_W        = ACC_W;
    localparam int NUM_W         = 64;
    localparam int L2_SHIFT      = 48 - 2 * FRACTION_BITS;
    localparam int ONE_SHIFT     = 24;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_err;

    // Operation codes
    localparam t_mode MODE_DIM = 2'd0;
    localparam t_mode MODE_DOT = 2'd1;
    localparam t_mode MODE_L2  = 2'd2;
    localparam t_mode MODE_COS = 2'd3;

    // Error codes
    localparam t_err ERR_OK   = 2'd0;
    localparam t_err ERR_DIM  = 2'd1;
    localparam t_err ERR_ZERO = 2'd2;
    localparam t_err ERR_RSVD = 2'd3;

    // Element product steps
    localparam logic [1:0] OP_AA = 2'd0;
    localparam logic [1:0] OP_BB = 2'd1;
    localparam logic [1:0] OP_AB = 2'd2;
    localparam logic [1:0] OP_DD = 2'd3;

endpackage
`default_nettype wire

// File: hw/rtl/vdu_mul.sv
`default_nettype none
module vdu_mul
    import vdu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ACC_W-1:0]  i_x,
    input  wire logic [ACC_W-1:0]  i_y,
    output logic                   o_done,
    output logic [RAD_W-1:0]       o_prod
);

    localparam int CNT_W = $clog2(ACC_W);

    logic [RAD_W-1:0] r_x;
    logic [ACC_W-1:0] r_y;
    logic [RAD_W-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // Add one shifted partial product per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= RAD_W'(i_x);
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_y[0]) r_acc <= r_acc + r_x;
            r_x <= r_x << 1;
            r_y <= r_y >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

// File: hw/rtl/vdu_sqrt.sv
`default_nettype none
module vdu_sqrt
    import vdu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic              take;

    // One root bit per cycle, digit pair from the top of the radicand
    assign rem_sh = {r_rem[ROOT_W:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= take ? (ROOT_W + 2)'(rem_sh - trial) : (ROOT_W + 2)'(rem_sh);
            r_root <= {r_root[ROOT_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

// File: hw/rtl/vdu_div.sv
`default_nettype none
module vdu_div
    import vdu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [ROOT_W-1:0] i_den,
    output logic                   o_done,
    output logic [NUM_W-1:0]       o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0]  r_num;
    logic [ROOT_W-1:0] r_den;
    logic [ROOT_W-1:0] r_rem;
    logic [NUM_W-1:0]  r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W:0]   rem_sh;
    logic              take;

    // Restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign take   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= r_num << 1;
            r_rem  <= take ? ROOT_W'(rem_sh - {1'b0, r_den}) : ROOT_W'(rem_sh);
            r_quot <= {r_quot[NUM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// File: hw/rtl/vector_distance_unit.sv
`default_nettype none
// Channel   Dir  Payload
// s_axis    in   tdata {b_elem, a_elem}, tuser {b_present, a_present, mode}, tlast last
// m_axis    out  tdata {zero pad, value}, tuser error_code
//
// Each element pair runs four products through one shared
// 17x17 multiplier, then one accumulate and one return to idle.
// A closing pair adds a square root for euclidean mode and a multiply,
// a square root and a divide for cosine mode.
// Reset is synchronous, active low, and clears all sums and counts.
// Input stalls while an item is in work or a result waits for the output register.
module vector_distance_unit
    import vdu_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // a_elem[15:0], b_elem[31:16]
    input  wire logic [3:0]  s_axis_tuser,  // mode[1:0], a_present[2], b_present[3]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // value[40:0], zero[47:41]
    output logic [1:0]       m_axis_tuser   // error_code[1:0]
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_WMUL  = 3'd4;
    localparam logic [2:0] S_WSQ   = 3'd5;
    localparam logic [2:0] S_WDIV  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]                    r_state;
    logic [1:0]                    r_step;
    logic signed [ELEMENT_BITS-1:0] r_a;
    logic signed [ELEMENT_BITS-1:0] r_b;
    t_mode                         r_mode;
    logic                          r_last;
    logic                          r_ta;
    logic                          r_tb;
    logic [CW-1:0]                 r_cnt_a;
    logic [CW-1:0]                 r_cnt_b;
    logic signed [ACC_W-1:0]       r_dot;
    logic [ACC_W-1:0]              r_na;
    logic [ACC_W-1:0]              r_nb;
    logic [ACC_W-1:0]              r_diff;
    logic signed [PROD_W-1:0]      r_prod;
    logic [1:0]                    r_psel;
    logic                          r_pvld;
    logic [OUT_W-1:0]              r_val;
    t_err                          r_err;
    logic                          r_out_valid;
    logic [OUT_W-1:0]              r_out_val;
    t_err                          r_out_err;

    logic                          accept;
    logic                          in_ta;
    logic                          in_tb;
    logic signed [ELEMENT_BITS:0]  mul_x;
    logic signed [ELEMENT_BITS:0]  mul_y;
    logic signed [ELEMENT_BITS:0]  d_elem;
    logic [OUT_W-1:0]              p_ext;
    logic [OUT_W-1:0]              add_na;
    logic [OUT_W-1:0]              add_nb;
    logic [OUT_W-1:0]              add_diff;
    logic [OUT_W-1:0]              add_dot;
    logic                          dims_ok;
    logic                          mul_start;
    logic                          mul_done;
    logic [RAD_W-1:0]              mul_prod;
    logic                          sq_start;
    logic                          sq_done;
    logic [RAD_W-1:0]              sq_rad;
    logic [ROOT_W-1:0]             sq_root;
    logic                          div_start;
    logic                          div_done;
    logic [NUM_W-1:0]              div_num;
    logic [NUM_W-1:0]              div_quot;
    logic [ACC_W-1:0]              dot_mag;
    logic [42:0]                   cos_q;
    logic signed [44:0]            cos_v;
    logic [OUT_W-1:0]              cos_out;
    logic                          out_free;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_ta = s_axis_tuser[2] && (r_cnt_a < CW'(MAX_ELEMENTS));
    assign in_tb = s_axis_tuser[3] && (r_cnt_b < CW'(MAX_ELEMENTS));
    assign dims_ok = (r_cnt_a != '0) && (r_cnt_a == r_cnt_b);
    assign out_free = !r_out_valid || m_axis_tready;

    // Select operands of the shared element multiplier
    assign d_elem = (ELEMENT_BITS + 1)'(r_a) - (ELEMENT_BITS + 1)'(r_b);
    always_comb begin
        case (r_step)
            OP_AA: begin mul_x = (ELEMENT_BITS + 1)'(r_a); mul_y = (ELEMENT_BITS + 1)'(r_a); end
            OP_BB: begin mul_x = (ELEMENT_BITS + 1)'(r_b); mul_y = (ELEMENT_BITS + 1)'(r_b); end
            OP_AB: begin mul_x = (ELEMENT_BITS + 1)'(r_a); mul_y = (ELEMENT_BITS + 1)'(r_b); end
            default: begin mul_x = d_elem; mul_y = d_elem; end
        endcase
    end

    // Saturating adds of the registered product
    assign p_ext    = OUT_W'(r_prod);
    assign add_na   = {1'b0, r_na} + p_ext;
    assign add_nb   = {1'b0, r_nb} + p_ext;
    assign add_diff = {1'b0, r_diff} + p_ext;
    assign add_dot  = {r_dot[ACC_W-1], r_dot} + p_ext;

    // Closing arithmetic operands
    assign dot_mag   = r_dot[ACC_W-1] ? ACC_W'(-r_dot) : ACC_W'(r_dot);
    assign mul_start = (r_state == S_FIN) && (r_mode == MODE_COS) && dims_ok
                       && (r_na != '0) && (r_nb != '0);
    assign sq_start  = ((r_state == S_FIN) && (r_mode == MODE_L2) && dims_ok)
                       || ((r_state == S_WMUL) && mul_done);
    assign sq_rad    = (r_state == S_FIN) ? (RAD_W'(r_diff) << L2_SHIFT) : mul_prod;
    assign div_start = (r_state == S_WSQ) && sq_done && (r_mode == MODE_COS);
    assign div_num   = {dot_mag, 24'b0} + NUM_W'(sq_root >> 1);

    // Clamp quotient, then form one minus or one plus it and saturate
    assign cos_q   = (div_quot > (NUM_W'(1) << 42)) ? (43'd1 << 42) : div_quot[42:0];
    assign cos_v   = r_dot[ACC_W-1] ? (45'sd1 <<< ONE_SHIFT) + $signed({2'b0, cos_q})
                                    : (45'sd1 <<< ONE_SHIFT) - $signed({2'b0, cos_q});
    assign cos_out = (cos_v > 45'sd1099511627775) ? {1'b0, {(OUT_W - 1){1'b1}}} :
                     (cos_v < -45'sd1099511627776) ? {1'b1, {(OUT_W - 1){1'b0}}} :
                     cos_v[OUT_W-1:0];

    vdu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (r_na),
        .i_y     (r_nb),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    vdu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    vdu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (sq_root),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Hold the element pair of the current request; register each product and its step
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a    <= s_axis_tdata[15:0];
            r_b    <= s_axis_tdata[31:16];
            r_mode <= s_axis_tuser[1:0];
            r_last <= s_axis_tlast;
            r_ta   <= in_ta;
            r_tb   <= in_tb;
        end
        r_prod <= PROD_W'(mul_x * mul_y);
        r_psel <= r_step;
    end

    // Sequencer, sums and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_pvld  <= 1'b0;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_dot   <= '0;
            r_na    <= '0;
            r_nb    <= '0;
            r_diff  <= '0;
            r_val   <= '0;
            r_err   <= ERR_OK;
        end else begin
            r_pvld <= (r_state == S_MUL);

            // Fold the previous product into its sum
            if (r_pvld) begin
                case (r_psel)
                    OP_AA: if (r_ta) r_na <= add_na[ACC_W] ? '1 : add_na[ACC_W-1:0];
                    OP_BB: if (r_tb) r_nb <= add_nb[ACC_W] ? '1 : add_nb[ACC_W-1:0];
                    OP_AB: if (r_ta && r_tb) begin
                        if (add_dot[ACC_W] != add_dot[ACC_W-1])
                            r_dot <= add_dot[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                                    : {1'b0, {(ACC_W - 1){1'b1}}};
                        else
                            r_dot <= add_dot[ACC_W-1:0];
                    end
                    default: if (r_ta && r_tb)
                        r_diff <= add_diff[ACC_W] ? '1 : add_diff[ACC_W-1:0];
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (in_ta) r_cnt_a <= r_cnt_a + 1'b1;
                        if (in_tb) r_cnt_b <= r_cnt_b + 1'b1;
                        r_step  <= OP_AA;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == OP_DD) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_val <= '0;
                    r_err <= ERR_OK;
                    if (r_mode == MODE_DIM) begin
                        r_val   <= OUT_W'(r_cnt_a);
                        r_state <= S_EMIT;
                    end else if (!dims_ok) begin
                        r_err   <= ERR_DIM;
                        r_state <= S_EMIT;
                    end else if (r_mode == MODE_DOT) begin
                        r_val   <= {r_dot[ACC_W-1], r_dot};
                        r_state <= S_EMIT;
                    end else if (r_mode == MODE_L2) begin
                        r_state <= S_WSQ;
                    end else if ((r_na == '0) || (r_nb == '0)) begin
                        r_err   <= ERR_ZERO;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_WMUL;
                    end
                end
                S_WMUL: begin
                    if (mul_done) r_state <= S_WSQ;
                end
                S_WSQ: begin
                    if (sq_done) begin
                        if (r_mode == MODE_L2) begin
                            r_val   <= OUT_W'(sq_root);
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_WDIV;
                        end
                    end
                end
                S_WDIV: begin
                    if (div_done) begin
                        r_val   <= cos_out;
                        r_state <= S_EMIT;
                    end
                end
                default: begin
                    // Hand the result over and clear all sums
                    if (out_free) begin
                        r_cnt_a <= '0;
                        r_cnt_b <= '0;
                        r_dot   <= '0;
                        r_na    <= '0;
                        r_nb    <= '0;
                        r_diff  <= '0;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_out_val <= r_val;
            r_out_err <= r_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(48 - OUT_W){1'b0}}, r_out_val};
    assign m_axis_tuser  = r_out_err;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CW'(MAX_ELEMENTS)) && (r_cnt_b <= CW'(MAX_ELEMENTS)))
        else $error("element count beyond limit");

    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MUL) && (r_step == OP_AA))
        else $error("accepted request did not start products");

    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_WSQ))
        else $error("square root finished outside its wait");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_err != ERR_RSVD))
        else $error("reserved error code on output");
`endif

endmodule
`default_nettype wire
